// ===== src/rwb_pkg.sv =====
// ----------------------------------------------------------------------------
// rwb_pkg: shared types and constants for the radial warp remapper
// Frame geometry, fixed point widths, register and opcode names, item structs.
// ----------------------------------------------------------------------------
package rwb_pkg;

  // Frame store geometry
  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int RSZ_W    = ROW_W + 1;      // holds MAX_ROWS itself
  localparam int CSZ_W    = COL_W + 1;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;

  // Fixed point: Q2.16 coordinates
  localparam int QF         = 16;
  localparam int DIV_STEPS  = QF + 1;       // quotient bits of idx*2^17/size
  localparam int SQRT_STEPS = 17;           // root bits
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int XN_W       = QF + 2;
  localparam int SQ_W       = 36;
  localparam int XH_W       = QF + 3;
  localparam int T_W        = QF + 1;
  localparam int AR_W       = T_W + RSZ_W - 1;
  localparam int AC_W       = T_W + CSZ_W - 1;
  localparam int W_W        = 2 * CH_W + 1; // bilinear weight, up to 2^16
  localparam int ACC_W      = W_W + CH_W + 2;

  // Stream words
  localparam int DATA_W  = ROW_W + COL_W + PIX_W;
  localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = FPTR_W + 1;

  // Configuration
  localparam int CFG_W = 11;
  localparam logic REG_FRAME_ROWS = 1'b0;
  localparam logic REG_FRAME_COLS = 1'b1;
  localparam logic [RSZ_W-1:0] ROWS_RST = RSZ_W'(480);
  localparam logic [CSZ_W-1:0] COLS_RST = CSZ_W'(640);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_P11 = 2'd0,
    PH_P21 = 2'd1,
    PH_P12 = 2'd2,
    PH_P22 = 2'd3
  } phase_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;   // ch2, ch1, ch0 (ch0 low)
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] i1;
    logic [ROW_W-1:0] i2;
    logic [COL_W-1:0] j1;
    logic [COL_W-1:0] j2;
    logic [CH_W-1:0]  u;
    logic [CH_W-1:0]  v;
  } samp_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  u;
    logic [CH_W-1:0]  v;
    logic [PIX_W-1:0] p11;
    logic [PIX_W-1:0] p21;
    logic [PIX_W-1:0] p12;
    logic [PIX_W-1:0] p22;
  } blend_in_t;

endpackage

// ===== src/rwb_coord.sv =====
// ----------------------------------------------------------------------------
// rwb_coord: coordinate pipeline
// Normalize, radius, half-radius scale and map back to sample positions.
// Dividers and square root run one bit per stage; one word may enter per cycle while the output is not held.
// ----------------------------------------------------------------------------
module rwb_coord import rwb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RSZ_W-1:0] rows_used,
  input  logic [CSZ_W-1:0] cols_used,
  input  logic             in_vld,
  input  item_t            in_item,
  output logic             in_rdy,
  output logic             out_vld,
  output item_t            out_item,
  output samp_t            out_samp,
  input  logic             take
);

  logic en;
  assign en     = !out_vld || take;
  assign in_rdy = en;

  // Stage A: clamp request to the frame in use
  logic             a_vld;
  item_t            a_item;
  logic [ROW_W-1:0] a_ri;
  logic [COL_W-1:0] a_cj;
  logic [ROW_W-1:0] ri_c;
  logic [COL_W-1:0] cj_c;

  always_comb begin
    ri_c = ({1'b0, in_item.row} < rows_used) ? in_item.row : ROW_W'(rows_used - RSZ_W'(1));
    cj_c = ({1'b0, in_item.col} < cols_used) ? in_item.col : COL_W'(cols_used - CSZ_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      a_ri   <= ri_c;
      a_cj   <= cj_c;
    end
  end

  // Restoring dividers: idx * 2^17 / size, one quotient bit per stage
  logic             dv_vld  [DIV_STEPS];
  item_t            dv_item [DIV_STEPS];
  logic [RSZ_W-1:0] dr_rem  [DIV_STEPS];
  logic [QF:0]      dr_q    [DIV_STEPS];
  logic [CSZ_W-1:0] dc_rem  [DIV_STEPS];
  logic [QF:0]      dc_q    [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic             pv;
    item_t            pi;
    logic [RSZ_W-1:0] prr;
    logic [QF:0]      prq;
    logic [CSZ_W-1:0] pcr;
    logic [QF:0]      pcq;
    logic [RSZ_W:0]   rt;
    logic [CSZ_W:0]   ct;
    logic             rge;
    logic             cge;

    if (k == 0) begin : g_first
      assign pv  = a_vld;
      assign pi  = a_item;
      assign prr = RSZ_W'(a_ri);
      assign prq = '0;
      assign pcr = CSZ_W'(a_cj);
      assign pcq = '0;
    end else begin : g_next
      assign pv  = dv_vld[k-1];
      assign pi  = dv_item[k-1];
      assign prr = dr_rem[k-1];
      assign prq = dr_q[k-1];
      assign pcr = dc_rem[k-1];
      assign pcq = dc_q[k-1];
    end

    assign rt  = {prr, 1'b0};
    assign ct  = {pcr, 1'b0};
    assign rge = rt >= {1'b0, rows_used};
    assign cge = ct >= {1'b0, cols_used};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (en) begin
        dv_vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_item[k] <= pi;
        dr_rem[k]  <= rge ? RSZ_W'(rt - {1'b0, rows_used}) : RSZ_W'(rt);
        dr_q[k]    <= {prq[QF-1:0], rge};
        dc_rem[k]  <= cge ? CSZ_W'(ct - {1'b0, cols_used}) : CSZ_W'(ct);
        dc_q[k]    <= {pcq[QF-1:0], cge};
      end
    end
  end

  // Stage SQ: signed Q2.16 coordinates and their squares
  logic signed [XN_W-1:0]   xn_c;
  logic signed [XN_W-1:0]   yn_c;
  logic signed [2*XN_W-1:0] pxx;
  logic signed [2*XN_W-1:0] pyy;
  logic                     sq_vld;
  item_t                    sq_item;
  logic signed [XN_W-1:0]   sq_xn;
  logic signed [XN_W-1:0]   sq_yn;
  logic [SQ_W-1:0]          sq_xx;
  logic [SQ_W-1:0]          sq_yy;

  always_comb begin
    xn_c = {1'b0, dr_q[DIV_STEPS-1]} - XN_W'(1 << QF);
    yn_c = {1'b0, dc_q[DIV_STEPS-1]} - XN_W'(1 << QF);
    pxx  = xn_c * xn_c;
    pyy  = yn_c * yn_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (en) begin
      sq_vld <= dv_vld[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_item <= dv_item[DIV_STEPS-1];
      sq_xn   <= xn_c;
      sq_yn   <= yn_c;
      sq_xx   <= SQ_W'(pxx);
      sq_yy   <= SQ_W'(pyy);
    end
  end

  // Stage SUM: radius squared
  logic                   su_vld;
  item_t                  su_item;
  logic signed [XN_W-1:0] su_xn;
  logic signed [XN_W-1:0] su_yn;
  logic [SQ_W-1:0]        su_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      su_vld <= 1'b0;
    end else if (en) begin
      su_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_item <= sq_item;
      su_xn   <= sq_xn;
      su_yn   <= sq_yn;
      su_rem  <= sq_xx + sq_yy;
    end
  end

  // Digit-by-digit square root, one root bit per stage
  logic                   sr_vld  [SQRT_STEPS];
  item_t                  sr_item [SQRT_STEPS];
  logic signed [XN_W-1:0] sr_xn   [SQRT_STEPS];
  logic signed [XN_W-1:0] sr_yn   [SQRT_STEPS];
  logic [SQ_W-1:0]        sr_rem  [SQRT_STEPS];
  logic [ROOT_W-1:0]      sr_root [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - s;
    logic                   pv;
    item_t                  pi;
    logic signed [XN_W-1:0] px;
    logic signed [XN_W-1:0] py;
    logic [SQ_W-1:0]        prem;
    logic [ROOT_W-1:0]      proot;
    logic [SQ_W-1:0]        trial;
    logic                   fits;

    if (s == 0) begin : g_first
      assign pv    = su_vld;
      assign pi    = su_item;
      assign px    = su_xn;
      assign py    = su_yn;
      assign prem  = su_rem;
      assign proot = '0;
    end else begin : g_next
      assign pv    = sr_vld[s-1];
      assign pi    = sr_item[s-1];
      assign px    = sr_xn[s-1];
      assign py    = sr_yn[s-1];
      assign prem  = sr_rem[s-1];
      assign proot = sr_root[s-1];
    end

    // (root + 2^K)^2 - root^2
    assign trial = (SQ_W'(proot) << (K + 1)) + (SQ_W'(1) << (2 * K));
    assign fits  = prem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_vld[s] <= 1'b0;
      end else if (en) begin
        sr_vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_item[s] <= pi;
        sr_xn[s]   <= px;
        sr_yn[s]   <= py;
        sr_rem[s]  <= fits ? prem - trial : prem;
        sr_root[s] <= fits ? (proot | (ROOT_W'(1) << K)) : proot;
      end
    end
  end

  // Stage MUL: half-radius scale, floor toward minus infinity
  localparam int LS = SQRT_STEPS - 1;
  logic signed [XN_W-1:0]   root_s;
  logic signed [2*XN_W-1:0] pmx;
  logic signed [2*XN_W-1:0] pmy;
  logic                     mu_vld;
  item_t                    mu_item;
  logic signed [XH_W-1:0]   mu_xh;
  logic signed [XH_W-1:0]   mu_yh;

  always_comb begin
    root_s = $signed({1'b0, sr_root[LS]});
    pmx    = sr_xn[LS] * root_s;
    pmy    = sr_yn[LS] * root_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_vld <= 1'b0;
    end else if (en) begin
      mu_vld <= sr_vld[LS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_item <= sr_item[LS];
      mu_xh   <= XH_W'(pmx >>> (QF + 1));
      mu_yh   <= XH_W'(pmy >>> (QF + 1));
    end
  end

  // Stage DEN1: shift to [0, 2) and scale by half the size
  logic signed [XH_W-1:0] tx_s;
  logic signed [XH_W-1:0] ty_s;
  logic [T_W-1:0]         tx;
  logic [T_W-1:0]         ty;
  logic [AR_W:0]          prx;
  logic [AC_W:0]          pry;
  logic                   de_vld;
  item_t                  de_item;
  logic [AR_W-1:0]        de_ar;
  logic [AC_W-1:0]        de_ac;

  always_comb begin
    tx_s = mu_xh + XH_W'(1 << QF);
    ty_s = mu_yh + XH_W'(1 << QF);
    tx   = tx_s[XH_W-1] ? '0 : T_W'(tx_s);
    ty   = ty_s[XH_W-1] ? '0 : T_W'(ty_s);
    prx  = tx * rows_used;
    pry  = ty * cols_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      de_vld <= 1'b0;
    end else if (en) begin
      de_vld <= mu_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      de_item <= mu_item;
      de_ar   <= prx[AR_W:1];
      de_ac   <= pry[AC_W:1];
    end
  end

  // Stage DEN2: clamp to the last row/column, split index and weight
  logic [AR_W-1:0]  lim_r;
  logic [AC_W-1:0]  lim_c;
  logic [AR_W-1:0]  xa;
  logic [AC_W-1:0]  ya;
  samp_t            samp_c;

  always_comb begin
    lim_r     = AR_W'({rows_used - RSZ_W'(1), QF'(0)});
    lim_c     = AC_W'({cols_used - CSZ_W'(1), QF'(0)});
    xa        = (de_ar > lim_r) ? lim_r : de_ar;
    ya        = (de_ac > lim_c) ? lim_c : de_ac;
    samp_c.i1 = xa[QF+ROW_W-1:QF];
    samp_c.v  = xa[QF-1:QF-CH_W];
    samp_c.j1 = ya[QF+COL_W-1:QF];
    samp_c.u  = ya[QF-1:QF-CH_W];
    samp_c.i2 = ((RSZ_W'(samp_c.i1) + RSZ_W'(1)) < rows_used) ?
                ROW_W'(samp_c.i1 + ROW_W'(1)) : ROW_W'(rows_used - RSZ_W'(1));
    samp_c.j2 = ((CSZ_W'(samp_c.j1) + CSZ_W'(1)) < cols_used) ?
                COL_W'(samp_c.j1 + COL_W'(1)) : COL_W'(cols_used - CSZ_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= de_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= de_item;
      out_samp <= samp_c;
    end
  end

endmodule

// ===== src/rwb_frame.sv =====
// ----------------------------------------------------------------------------
// rwb_frame: frame store and neighbor fetch
// Single-port pixel memory. A write word stores its pixel directly; a read word
// fetches its four neighbors one after another, only while the queue has credit.
// ----------------------------------------------------------------------------
module rwb_frame import rwb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  item_t     in_item,
  input  samp_t     in_samp,
  input  logic      credit_ok,
  output logic      take,
  output logic      rd_take,
  output logic      bl_vld,
  output blend_in_t bl_in
);

  logic [PIX_W-1:0] mem [MAX_ROWS * MAX_COLS];
  logic [PIX_W-1:0] q;
  phase_t           phase;
  logic             is_wr;
  logic             rd_go;
  logic [ADDR_W-1:0] addr;
  logic             rd_vld;
  phase_t           rd_tag;
  logic [PIX_W-1:0] p11;
  logic [PIX_W-1:0] p21;
  logic [PIX_W-1:0] p12;
  logic [ROW_W-1:0] m_row;
  logic [COL_W-1:0] m_col;
  logic [CH_W-1:0]  m_u;
  logic [CH_W-1:0]  m_v;

  // Control
  always_comb begin
    is_wr   = in_vld && (in_item.op == OP_WRITE);
    rd_go   = in_vld && (in_item.op == OP_READ) && credit_ok;
    rd_take = rd_go && (phase == PH_P22);
    take    = is_wr || rd_take;
  end

  // Address select
  always_comb begin
    if (is_wr) begin
      addr = {in_item.row, in_item.col};
    end else begin
      unique case (phase)
        PH_P11:  addr = {in_samp.i1, in_samp.j1};
        PH_P21:  addr = {in_samp.i2, in_samp.j1};
        PH_P12:  addr = {in_samp.i1, in_samp.j2};
        PH_P22:  addr = {in_samp.i2, in_samp.j2};
        default: addr = {in_samp.i1, in_samp.j1};
      endcase
    end
  end

  // Memory port
  always_ff @(posedge clk) begin
    if (is_wr) begin
      mem[addr] <= in_item.pix;
    end
    q <= mem[addr];
  end

  // Fetch phase and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_P11;
      rd_vld <= 1'b0;
      rd_tag <= PH_P11;
    end else begin
      if (rd_go) begin
        phase <= phase_t'(phase + 2'd1);
      end
      rd_vld <= rd_go;
      rd_tag <= phase;
    end
  end

  // Collect neighbors
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      unique case (rd_tag)
        PH_P11:  p11 <= q;
        PH_P21:  p21 <= q;
        PH_P12:  p12 <= q;
        PH_P22:  ;
        default: ;
      endcase
    end
    if (rd_take) begin
      m_row <= in_item.row;
      m_col <= in_item.col;
      m_u   <= in_samp.u;
      m_v   <= in_samp.v;
    end
  end

  assign bl_vld    = rd_vld && (rd_tag == PH_P22);
  assign bl_in.row = m_row;
  assign bl_in.col = m_col;
  assign bl_in.u   = m_u;
  assign bl_in.v   = m_v;
  assign bl_in.p11 = p11;
  assign bl_in.p21 = p21;
  assign bl_in.p12 = p12;
  assign bl_in.p22 = q;

endmodule

// ===== src/rwb_blend.sv =====
// ----------------------------------------------------------------------------
// rwb_blend: bilinear blend and output queue
// Weights in one stage, per-channel weighted sums in the next, then a small
// queue toward the master side with a slot count that gates new fetches.
// ----------------------------------------------------------------------------
module rwb_blend import rwb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               bl_vld,
  input  blend_in_t          bl_in,
  input  logic               rd_take,
  output logic               credit_ok,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata   // row, col, ch0, ch1, ch2, zero pad
);

  // Weight stage
  logic             w_vld;
  logic [W_W-1:0]   w11;
  logic [W_W-1:0]   w21;
  logic [W_W-1:0]   w12;
  logic [W_W-1:0]   w22;
  blend_in_t        w_in;
  logic [CH_W:0]    ua;
  logic [CH_W:0]    va;
  logic [CH_W:0]    ub;
  logic [CH_W:0]    vb;

  always_comb begin
    ub = (CH_W + 1)'(1 << CH_W) - (CH_W + 1)'(bl_in.u);
    vb = (CH_W + 1)'(1 << CH_W) - (CH_W + 1)'(bl_in.v);
    ua = (CH_W + 1)'(bl_in.u);
    va = (CH_W + 1)'(bl_in.v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else begin
      w_vld <= bl_vld;
    end
  end

  // full 2^16 weight needs the 17-bit product
  always_ff @(posedge clk) begin
    w_in <= bl_in;
    w11  <= W_W'(ub) * W_W'(vb);
    w21  <= W_W'(ub) * W_W'(va);
    w12  <= W_W'(ua) * W_W'(vb);
    w22  <= W_W'(ua) * W_W'(va);
  end

  // Sum stage
  logic                  s_vld;
  logic [DATA_W-1:0]     s_word;
  logic [PIX_W-1:0]      blended;
  logic [ACC_W-1:0]      acc [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(w11) * ACC_W'(w_in.p11[c*CH_W +: CH_W])
             + ACC_W'(w21) * ACC_W'(w_in.p21[c*CH_W +: CH_W])
             + ACC_W'(w12) * ACC_W'(w_in.p12[c*CH_W +: CH_W])
             + ACC_W'(w22) * ACC_W'(w_in.p22[c*CH_W +: CH_W]);
      blended[c*CH_W +: CH_W] = acc[c][2*CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= w_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_word <= {blended, w_in.col, w_in.row};
  end

  // Output queue
  logic [DATA_W-1:0] fifo [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr;
  logic [FPTR_W-1:0] rptr;
  logic [FCNT_W-1:0] fcnt;
  logic [FCNT_W-1:0] slots;
  logic              pop;

  assign pop       = m_tvalid && m_tready;
  assign m_tvalid  = fcnt != '0;
  assign m_tdata   = TDATA_W'(fifo[rptr]);
  assign credit_ok = slots < FCNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (s_vld) begin
      fifo[wptr] <= s_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      fcnt  <= '0;
      slots <= '0;
    end else begin
      if (s_vld) begin
        wptr <= wptr + FPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + FPTR_W'(1);
      end
      fcnt  <= fcnt + FCNT_W'(s_vld) - FCNT_W'(pop);
      // counts words from fetch end until they leave the queue
      slots <= slots + FCNT_W'(rd_take) - FCNT_W'(pop);
    end
  end

endmodule

// ===== src/radial_warp_bilinear.sv =====
// ----------------------------------------------------------------------------
// radial_warp_bilinear: radial distortion remapper with bilinear blend
// Top level: configuration registers, stream unpacking, pipeline hookup.
// ----------------------------------------------------------------------------
// A write word (tuser = 0) stores one pixel at the frame memory; a read word
// (tuser = 1) makes four neighbor fetches there, one after another on the
// single-port frame store, and waits while the output queue has no credit.
// Writes are taken one word per cycle while no read ahead holds the pipeline.
// The coordinate pipeline in front is 40 stages deep (bit-per-stage dividers
// and square root); the blend registers weights, then sums, before the
// eight-word output queue. The frame store is not cleared: pixels must be written before they are read.
module radial_warp_bilinear import rwb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // row, col, ch0, ch1, ch2, zero pad
  input  logic [0:0]         s_tuser,   // op
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // row, col, ch0, ch1, ch2, zero pad
);

  // Configuration registers
  logic [RSZ_W-1:0] frame_rows;
  logic [CSZ_W-1:0] frame_cols;
  logic [RSZ_W-1:0] rows_used;
  logic [CSZ_W-1:0] cols_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_RST;
      frame_cols <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_ROWS: frame_rows <= cfg_data[RSZ_W-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[CSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store
  always_comb begin
    priority if (frame_rows < RSZ_W'(2)) rows_used = RSZ_W'(2);
    else if (frame_rows > RSZ_W'(MAX_ROWS)) rows_used = RSZ_W'(MAX_ROWS);
    else rows_used = frame_rows;
    priority if (frame_cols < CSZ_W'(2)) cols_used = CSZ_W'(2);
    else if (frame_cols > CSZ_W'(MAX_COLS)) cols_used = CSZ_W'(MAX_COLS);
    else cols_used = frame_cols;
  end

  // Unpack input word
  item_t in_item;
  assign in_item.op  = op_t'(s_tuser[0]);
  assign in_item.row = s_tdata[ROW_W-1:0];
  assign in_item.col = s_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_item.pix = s_tdata[DATA_W-1:ROW_W+COL_W];

  logic      c_vld;
  item_t     c_item;
  samp_t     c_samp;
  logic      take;
  logic      rd_take;
  logic      credit_ok;
  logic      bl_vld;
  blend_in_t bl_in;

  rwb_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .in_vld    (s_tvalid),
    .in_item   (in_item),
    .in_rdy    (s_tready),
    .out_vld   (c_vld),
    .out_item  (c_item),
    .out_samp  (c_samp),
    .take      (take)
  );

  rwb_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (c_vld),
    .in_item   (c_item),
    .in_samp   (c_samp),
    .credit_ok (credit_ok),
    .take      (take),
    .rd_take   (rd_take),
    .bl_vld    (bl_vld),
    .bl_in     (bl_in)
  );

  rwb_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .bl_vld    (bl_vld),
    .bl_in     (bl_in),
    .rd_take   (rd_take),
    .credit_ok (credit_ok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
